### hdl/first_fit_heap_allocator_macros.svh
// Assertion macros used by the allocator checker
`ifndef FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define FFHA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define FFHA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/ffha_pkg.sv
// Package: heap geometry, header format, request and result types, status codes
package ffha_pkg;

    localparam int HEAP_BYTES = 32768;
    localparam int GRANULES   = (HEAP_BYTES + 7) / 8;
    localparam int IDX_W      = $clog2(GRANULES);
    localparam int SZ_W       = IDX_W + 1;
    localparam int NEED_W     = 14;
    localparam int SPLIT_G    = 3;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_ZERO   = 3'd1;
    localparam logic [2:0] ST_NOFIT  = 3'd2;
    localparam logic [2:0] ST_RANGE  = 3'd3;
    localparam logic [2:0] ST_NOTBLK = 3'd4;
    localparam logic [2:0] ST_DOUBLE = 3'd5;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef struct packed {
        logic            valid;
        logic            free;
        logic [SZ_W-1:0] size;
    } hdr_t;

    typedef struct packed {
        logic        cmd;
        logic [15:0] req_bytes;
        logic [14:0] user_offset;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [14:0] granted_offset;
        logic [31:0] free_bytes;
        logic [31:0] alloc_total;
        logic [31:0] release_total;
    } rsp_t;

endpackage

### hdl/first_fit_heap_allocator.sv
// First-fit heap allocator: header memory walk, split on alloc, forward merge on free
// Zero-size, out-of-range and misaligned requests end in idle; a free checks its header and
// may merge a free next block; an alloc reads each chain header and may split the block.
// One request at a time: the header memory's single read port and read latency set the
// walk rate. The result strobe done is high for one cycle and cannot be stalled.
// Reset: a clearing pass writes all GRANULES (4096) headers, busy held high.
module first_fit_heap_allocator
    import ffha_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t req,
    output logic done,
    output rsp_t rsp
);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_ACHK = 3'd2;
    localparam logic [2:0] S_AWR  = 3'd3;
    localparam logic [2:0] S_FCHK = 3'd4;
    localparam logic [2:0] S_FNXT = 3'd5;
    localparam logic [2:0] S_FCLR = 3'd6;

    hdr_t hdr_mem [GRANULES];
    hdr_t rd_data_reg;

    logic [2:0]        state_reg,  state_next;
    logic [IDX_W-1:0]  cnt_reg,    cnt_next;
    logic [NEED_W-1:0] need_reg,   need_next;
    logic [SZ_W-1:0]   walk_reg,   walk_next;
    logic [IDX_W-1:0]  idx_reg,    idx_next;
    logic [SZ_W-1:0]   sz_reg,     sz_next;
    logic [31:0]       fbc_reg,    fbc_next;
    logic [31:0]       alloc_reg,  alloc_next;
    logic [31:0]       rel_reg,    rel_next;
    logic              done_reg,   done_next;
    rsp_t              rsp_reg,    rsp_next;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    hdr_t             wr_data;
    logic [IDX_W-1:0] rd_addr;
    logic [2:0]       status_c;
    logic [14:0]      granted_c;
    logic [SZ_W:0]    sum_c;
    logic [NEED_W-1:0] need_c;

    // Header memory: one write port, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            hdr_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= hdr_mem[rd_addr];
    end

    // Sequence the clear pass, the chain walk and the header updates
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        need_next  = need_reg;
        walk_next  = walk_reg;
        idx_next   = idx_reg;
        sz_next    = sz_reg;
        fbc_next   = fbc_reg;
        alloc_next = alloc_reg;
        rel_next   = rel_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        wr_en      = 1'b0;
        wr_addr    = idx_reg;
        wr_data    = '0;
        rd_addr    = idx_reg;
        status_c   = ST_OK;
        granted_c  = '0;
        sum_c      = {1'b0, walk_reg} + {1'b0, rd_data_reg.size};
        need_c     = NEED_W'(({1'b0, req.req_bytes} + 17'd7) >> 3) + NEED_W'(1);

        unique case (state_reg)
            S_CLR:
            begin
                // Write one header a cycle; entry 0 spans the whole heap
                wr_en   = 1'b1;
                wr_addr = cnt_reg;
                if (cnt_reg == '0)
                begin
                    wr_data = '{valid: 1'b1, free: 1'b1, size: SZ_W'(GRANULES)};
                end
                cnt_next = cnt_reg + IDX_W'(1);
                if (cnt_reg == IDX_W'(GRANULES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    if (req.cmd == CMD_ALLOC)
                    begin
                        if (req.req_bytes == '0)
                        begin
                            status_c  = ST_ZERO;
                            done_next = 1'b1;
                        end
                        else
                        begin
                            need_next  = need_c;
                            walk_next  = '0;
                            idx_next   = '0;
                            rd_addr    = '0;
                            state_next = S_ACHK;
                        end
                    end
                    else if (req.user_offset < 15'd8 ||
                             {17'd0, req.user_offset} >= 32'(HEAP_BYTES))
                    begin
                        status_c  = ST_RANGE;
                        done_next = 1'b1;
                    end
                    else if (req.user_offset[2:0] != 3'd0)
                    begin
                        status_c  = ST_NOTBLK;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        idx_next   = IDX_W'(req.user_offset[14:3]) - IDX_W'(1);
                        rd_addr    = IDX_W'(req.user_offset[14:3]) - IDX_W'(1);
                        state_next = S_FCHK;
                    end
                end
            end
            S_ACHK:
            begin
                if (!rd_data_reg.valid)
                begin
                    status_c   = ST_NOFIT;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (rd_data_reg.free &&
                         32'(rd_data_reg.size) >= 32'(need_reg))
                begin
                    if (32'(rd_data_reg.size) >= 32'(need_reg) + 32'(SPLIT_G))
                    begin
                        // Split: write the tail header now, the head next cycle
                        wr_en      = 1'b1;
                        wr_addr    = IDX_W'(walk_reg + SZ_W'(need_reg));
                        wr_data    = '{valid: 1'b1, free: 1'b1,
                                       size: rd_data_reg.size - SZ_W'(need_reg)};
                        sz_next    = SZ_W'(need_reg);
                        state_next = S_AWR;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = IDX_W'(walk_reg);
                        wr_data    = '{valid: 1'b1, free: 1'b0, size: rd_data_reg.size};
                        fbc_next   = fbc_reg - ({rd_data_reg.size, 3'b000} - 32'd8);
                        alloc_next = alloc_reg + 32'd1;
                        granted_c  = 15'({walk_reg, 3'b000} + 32'd8);
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (rd_data_reg.size == '0 || sum_c >= (SZ_W+1)'(GRANULES))
                begin
                    status_c   = ST_NOFIT;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    // Advance to the next header on the chain
                    walk_next = SZ_W'(sum_c);
                    rd_addr   = IDX_W'(sum_c);
                end
            end
            S_AWR:
            begin
                wr_en      = 1'b1;
                wr_addr    = IDX_W'(walk_reg);
                wr_data    = '{valid: 1'b1, free: 1'b0, size: sz_reg};
                fbc_next   = fbc_reg - ({sz_reg, 3'b000} - 32'd8);
                alloc_next = alloc_reg + 32'd1;
                granted_c  = 15'({walk_reg, 3'b000} + 32'd8);
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_FCHK:
            begin
                sum_c = {2'b00, idx_reg} + {1'b0, rd_data_reg.size};
                if (!rd_data_reg.valid)
                begin
                    status_c   = ST_NOTBLK;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (rd_data_reg.free)
                begin
                    status_c   = ST_DOUBLE;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    fbc_next = fbc_reg + ({rd_data_reg.size, 3'b000} - 32'd8);
                    rel_next = rel_reg + 32'd1;
                    sz_next  = rd_data_reg.size;
                    if (sum_c < (SZ_W+1)'(GRANULES))
                    begin
                        // Look at the following block for a merge
                        walk_next  = SZ_W'(sum_c);
                        rd_addr    = IDX_W'(sum_c);
                        state_next = S_FNXT;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_data    = '{valid: 1'b1, free: 1'b1, size: rd_data_reg.size};
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_FNXT:
            begin
                wr_en = 1'b1;
                if (rd_data_reg.valid && rd_data_reg.free)
                begin
                    wr_data    = '{valid: 1'b1, free: 1'b1,
                                   size: sz_reg + rd_data_reg.size};
                    state_next = S_FCLR;
                end
                else
                begin
                    wr_data    = '{valid: 1'b1, free: 1'b1, size: sz_reg};
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_FCLR:
            begin
                // Drop the merged header
                wr_en      = 1'b1;
                wr_addr    = IDX_W'(walk_reg);
                wr_data    = '0;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Build the result from the updated counters
        if (done_next)
        begin
            rsp_next.status         = status_c;
            rsp_next.granted_offset = granted_c;
            rsp_next.free_bytes     = fbc_next;
            rsp_next.alloc_total    = alloc_next;
            rsp_next.release_total  = rel_next;
        end
    end

    // Hold control state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            cnt_reg   <= '0;
            fbc_reg   <= 32'(HEAP_BYTES) - 32'd8;
            alloc_reg <= '0;
            rel_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            fbc_reg   <= fbc_next;
            alloc_reg <= alloc_next;
            rel_reg   <= rel_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        need_reg <= need_next;
        walk_reg <= walk_next;
        idx_reg  <= idx_next;
        sz_reg   <= sz_next;
        rsp_reg  <= rsp_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

### hdl/ffha_checker.sv
// Port-level checker for the allocator, bound to the top level
`include "first_fit_heap_allocator_macros.svh"

module ffha_checker
    import ffha_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input req_t req,
    input logic done,
    input rsp_t rsp
);

    // An accepted transfer either keeps the block busy or returns at once
    `FFHA_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done, "accept lost")
    // Results appear only once the block is idle again
    `FFHA_ASSERT_NOW(a_done_idle, done, !busy, "result while busy")
    // Failed requests carry no offset
    `FFHA_ASSERT_NOW(a_fail_no_offset, done && rsp.status != ST_OK,
        rsp.granted_offset == '0, "offset on failure")
    // Status stays within its defined codes
    `FFHA_ASSERT_NOW(a_status_code, done, rsp.status <= ST_DOUBLE, "bad status")

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
);

### tb/sv/testbench.sv
// Self-checking testbench for the first-fit heap allocator
`timescale 1ns / 100ps

module testbench;
    import ffha_pkg::*;

    localparam int RANDOM_ITEMS = 1930;
    localparam int CALM_TAIL    = 200;

    // Track the heap headers and counters, queue the expected result per request
    class heap_scoreboard;
        bit          hdr_used[GRANULES];
        bit          hdr_open[GRANULES];
        int unsigned hdr_bytes[GRANULES];
        int unsigned free_est;
        int unsigned allocs;
        int unsigned frees;
        rsp_t        pending[$];
        int          errors;

        function new();
            for (int g = 0; g < GRANULES; g++)
            begin
                hdr_used[g]  = 0;
                hdr_open[g]  = 0;
                hdr_bytes[g] = 0;
            end
            hdr_used[0]  = 1;
            hdr_open[0]  = 1;
            hdr_bytes[0] = HEAP_BYTES;
            free_est = HEAP_BYTES - 8;
            allocs   = 0;
            frees    = 0;
            errors   = 0;
        endfunction

        // Walk the chain from offset zero and take the first free block that fits
        function logic [2:0] grant(int unsigned want, output int unsigned granted);
            int unsigned need;
            int unsigned off;
            int unsigned idx;
            int unsigned sz;
            int unsigned tail;
            granted = 0;
            if (want == 0)
                return ST_ZERO;
            need = ((want + 7) & ~32'd7) + 8;
            if (need < 16)
                need = 16;
            off = 0;
            while (off < HEAP_BYTES)
            begin
                idx = off >> 3;
                if ((off & 7) != 0 || idx >= GRANULES || !hdr_used[idx])
                    break;
                sz = hdr_bytes[idx];
                if (hdr_open[idx] && sz >= need)
                begin
                    // split off the tail when enough room is left over
                    if (sz >= need + 24)
                    begin
                        tail = (off + need) >> 3;
                        if (tail < GRANULES)
                        begin
                            hdr_used[tail]  = 1;
                            hdr_open[tail]  = 1;
                            hdr_bytes[tail] = sz - need;
                            hdr_bytes[idx]  = need;
                        end
                    end
                    hdr_open[idx] = 0;
                    free_est -= hdr_bytes[idx] - 8;
                    allocs++;
                    granted = off + 8;
                    return ST_OK;
                end
                if (sz == 0)
                    break;
                off += sz;
            end
            return ST_NOFIT;
        endfunction

        // Release a block and merge it with the next one when that one is free
        function logic [2:0] release_block(int unsigned p);
            int unsigned off;
            int unsigned idx;
            int unsigned nxt;
            int unsigned nidx;
            if (p < 8 || p >= HEAP_BYTES)
                return ST_RANGE;
            off = p - 8;
            if ((off & 7) != 0)
                return ST_NOTBLK;
            idx = off >> 3;
            if (idx >= GRANULES || !hdr_used[idx])
                return ST_NOTBLK;
            if (hdr_open[idx])
                return ST_DOUBLE;
            free_est += hdr_bytes[idx] - 8;
            frees++;
            hdr_open[idx] = 1;
            nxt = off + hdr_bytes[idx];
            if (nxt < HEAP_BYTES && (nxt & 7) == 0)
            begin
                nidx = nxt >> 3;
                if (nidx < GRANULES && hdr_used[nidx] && hdr_open[nidx])
                begin
                    hdr_bytes[idx] += hdr_bytes[nidx];
                    hdr_used[nidx]  = 0;
                    hdr_open[nidx]  = 0;
                    hdr_bytes[nidx] = 0;
                end
            end
            return ST_OK;
        endfunction

        // Note an accepted request and queue its expected result
        function rsp_t note(req_t r);
            rsp_t        e;
            int unsigned g;
            g = 0;
            if (r.cmd == CMD_ALLOC)
                e.status = grant(r.req_bytes, g);
            else
                e.status = release_block(r.user_offset);
            e.granted_offset = g[14:0];
            e.free_bytes     = free_est;
            e.alloc_total    = allocs;
            e.release_total  = frees;
            pending.push_back(e);
            return e;
        endfunction

        // Compare one result against the oldest expectation
        function void check(rsp_t got);
            rsp_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result %p", $realtime, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.status !== e.status)
            begin
                $display("%0t: status expected %0d actual %0d", $realtime, e.status, got.status);
                errors++;
            end
            if (got.granted_offset !== e.granted_offset)
            begin
                $display("%0t: granted_offset expected %0d actual %0d", $realtime,
                         e.granted_offset, got.granted_offset);
                errors++;
            end
            if (got.free_bytes !== e.free_bytes)
            begin
                $display("%0t: free_bytes expected %0d actual %0d", $realtime,
                         e.free_bytes, got.free_bytes);
                errors++;
            end
            if (got.alloc_total !== e.alloc_total)
            begin
                $display("%0t: alloc_total expected %0d actual %0d", $realtime,
                         e.alloc_total, got.alloc_total);
                errors++;
            end
            if (got.release_total !== e.release_total)
            begin
                $display("%0t: release_total expected %0d actual %0d", $realtime,
                         e.release_total, got.release_total);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    req_t req;
    logic done;
    rsp_t rsp;

    heap_scoreboard board;
    int unsigned    live[$];
    int unsigned    released[$];

    first_fit_heap_allocator uut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    // Generate the clock
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Check every result strobe
    always @(posedge clk)
    begin
        if (rst_n && done)
            board.check(rsp);
    end

    // Present one request, hold it until transfer, then drop start for the gap if one is given
    task automatic issue(logic c, int unsigned nbytes, int unsigned uoff, int gap);
        rsp_t e;
        int   k;
        start <= 1'b1;
        req   <= '{cmd: c, req_bytes: nbytes[15:0], user_offset: uoff[14:0]};
        do
            @(posedge clk);
        while (busy);
        e = board.note('{cmd: c, req_bytes: nbytes[15:0], user_offset: uoff[14:0]});
        // track live blocks so frees mostly hit real headers
        if (e.status == ST_OK && c == CMD_ALLOC)
            live.push_back(e.granted_offset);
        if (e.status == ST_OK && c == CMD_FREE)
        begin
            for (k = 0; k < live.size(); k++)
                if (live[k] == uoff)
                begin
                    live.delete(k);
                    break;
                end
            released.push_back(uoff);
            if (released.size() > 16)
                void'(released.pop_front());
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Random request: mostly balanced alloc/free of live blocks, some noise
    task automatic random_request(int gap);
        int unsigned pick;
        int unsigned sz;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            issue(CMD_FREE, $urandom_range(0, 65535), $urandom_range(0, 32767), gap);
        else if (pick < 13 && released.size() > 0)
            issue(CMD_FREE, 0, released[$urandom_range(0, released.size() - 1)], gap);
        else if (live.size() > 0 && (live.size() > 40 || pick < 50))
            issue(CMD_FREE, $urandom_range(0, 65535),
                  live[$urandom_range(0, live.size() - 1)], gap);
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 85)
                sz = $urandom_range(1, 200);
            else if (pick < 95)
                sz = $urandom_range(201, 4000);
            else
                sz = $urandom_range(0, 32768);
            issue(CMD_ALLOC, sz, $urandom_range(0, 32767), gap);
        end
    endtask

    // Stimulus
    initial
    begin
        int n;
        int gap;
        board = new();
        rst_n <= 1'b0;
        start <= 1'b0;
        req   <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: error codes, exact fit, split, merge, double free
        issue(CMD_ALLOC, 0, 0, 0);
        issue(CMD_ALLOC, 32768, 0, 0);
        issue(CMD_ALLOC, 32760, 32767, 1);
        issue(CMD_ALLOC, 1, 0, 0);
        issue(CMD_FREE, 0, 8, 0);
        issue(CMD_FREE, 0, 8, 2);
        issue(CMD_ALLOC, 1, 0, 0);
        issue(CMD_ALLOC, 8, 0, 0);
        issue(CMD_ALLOC, 9, 0, 0);
        issue(CMD_ALLOC, 65535, 0, 0);
        issue(CMD_FREE, 65535, 0, 0);
        issue(CMD_FREE, 0, 7, 3);
        issue(CMD_FREE, 0, 32767, 0);
        issue(CMD_FREE, 0, 17, 0);
        issue(CMD_FREE, 0, 16000, 0);
        issue(CMD_FREE, 0, 24, 0);
        issue(CMD_FREE, 0, 8, 0);
        issue(CMD_FREE, 0, 8, 0);
        issue(CMD_ALLOC, 4, 0, 0);
        issue(CMD_ALLOC, 32, 0, 0);
        issue(CMD_ALLOC, 30000, 0, 0);
        issue(CMD_ALLOC, 32768, 0, 0);

        // random traffic, with a final stretch at full rate
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            gap = 0;
            if (n < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 3) == 0)
                gap = $urandom_range(1, 5);
            random_request(gap);
        end
        start <= 1'b0;

        // drain outstanding results, then allow for latency
        n = 0;
        while (board.pending.size() > 0 && n < 200000)
        begin
            @(posedge clk);
            n++;
        end
        repeat (20) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #40000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
